[hw/rtl/spc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the shape pair collision test pipeline.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int SQ_STEPS  = 32;   // root bits
    localparam int DIV_STEPS = 24;   // quotient bits, enough for a unit direction

    localparam logic signed [51:0] Q_ONE  = 52'sd65536;
    localparam logic [32:0]        LEN_BIG = 33'h1_0000_0000;
    localparam logic [31:0]        S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0]        S32_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_PP = 2'd0,
        KIND_PS = 2'd1,
        KIND_SP = 2'd2,
        KIND_SS = 2'd3
    } kind_t;

    // item data riding along the root and divide stages
    typedef struct packed {
        logic              sph;
        logic              hit;
        logic              big;
        logic [31:0]       dir_x;
        logic [31:0]       dir_y;
        logic [31:0]       dir_z;
        logic [31:0]       depth;
        logic signed [32:0] dif_x;
        logic signed [32:0] dif_y;
        logic signed [32:0] dif_z;
        logic signed [32:0] rad;
    } side_t;

    function automatic logic [31:0] sat_q(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > $signed({32'h0, S32_MAX})) begin
            r = S32_MAX;
        end else if (v < $signed({32'hffff_ffff, S32_MIN})) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/spc_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module spc_isqrt (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [63:0]   in_rad,
    input  wire spc_pkg::side_t in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output spc_pkg::side_t     out_side
);

    logic           valid_reg [spc_pkg::SQ_STEPS];
    logic [63:0]    rad_reg   [spc_pkg::SQ_STEPS];
    logic [33:0]    rem_reg   [spc_pkg::SQ_STEPS];
    logic [31:0]    root_reg  [spc_pkg::SQ_STEPS];
    spc_pkg::side_t side_reg  [spc_pkg::SQ_STEPS];

    for (genvar k = 0; k < spc_pkg::SQ_STEPS; k++) begin : g_step
        logic           v_in;
        logic [63:0]    rad_in;
        logic [33:0]    rem_in;
        logic [31:0]    root_in;
        spc_pkg::side_t side_in;
        logic [35:0]    acc;
        logic [35:0]    trial;
        logic [33:0]    rem_next;
        logic [31:0]    root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign acc   = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_comb begin
            if (acc >= trial) begin
                rem_next  = 34'(acc - trial);
                root_next = {root_in[30:0], 1'b1};
            end else begin
                rem_next  = acc[33:0];
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_in[61:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[spc_pkg::SQ_STEPS-1];
    assign out_root  = root_reg[spc_pkg::SQ_STEPS-1];
    assign out_side  = side_reg[spc_pkg::SQ_STEPS-1];

endmodule
`default_nettype wire

[hw/rtl/spc_divq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_divq
// Three-lane pipelined restoring divider: floor(mag * 2^16 / len), one
// quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module spc_divq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [32:0]      in_len,
    input  wire logic [2:0][32:0] in_mag,
    input  wire spc_pkg::side_t   in_side,
    output logic                  out_valid,
    output logic [32:0]           out_len,
    output logic [2:0][23:0]      out_quo,
    output spc_pkg::side_t        out_side
);

    localparam int QW = spc_pkg::DIV_STEPS;

    logic                  valid_reg [QW];
    logic [32:0]           len_reg   [QW];
    logic [2:0][32:0]      rem_reg   [QW];
    logic [2:0][QW-1:0]    low_reg   [QW];
    logic [2:0][QW-1:0]    quo_reg   [QW];
    spc_pkg::side_t        side_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic               v_in;
        logic [32:0]        len_in;
        logic [2:0][32:0]   rem_in;
        logic [2:0][QW-1:0] low_in;
        logic [2:0][QW-1:0] quo_in;
        spc_pkg::side_t     side_in;
        logic [2:0][32:0]   rem_next;
        logic [2:0][QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign len_in  = in_len;
            assign side_in = in_side;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = {8'h00, in_mag[j][32:8]};
                assign low_in[j] = {in_mag[j][7:0], 16'h0000};
                assign quo_in[j] = '0;
            end
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign len_in  = len_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quo_in  = quo_reg[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane_op
            logic [33:0] acc;
            assign acc = {rem_in[j], low_in[j][QW-1]};
            always_comb begin
                if (acc >= {1'b0, len_in}) begin
                    rem_next[j] = 33'(acc - {1'b0, len_in});
                    quo_next[j] = {quo_in[j][QW-2:0], 1'b1};
                end else begin
                    rem_next[j] = acc[32:0];
                    quo_next[j] = {quo_in[j][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[k]  <= len_in;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
                for (int j = 0; j < 3; j++) begin
                    low_reg[k][j] <= {low_in[j][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_len   = len_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

[hw/rtl/shape_pair_collision_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shape_pair_collision_test
// Plane/sphere pair intersection in signed Q16.16, fully pipelined.
//
//   channel  ports                         direction
//   s_       kind, a_x..a_w, b_x..b_w      in  (valid/ready)
//   m_       hit, dir_x..dir_z, depth      out (valid/ready)
//
// One beat per cycle sustained while m_ready holds; path: stages 1-3, the
// bit-per-stage square root (32 stages), divider (24 stages), final and output.
// Reset clears all valid bits; no clearing pass.
// All stages hold while the skid register is full; s_ready is registered-only.
// ----------------------------------------------------------------------------
module shape_pair_collision_test (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [31:0] s_a_x,
    input  wire logic [31:0] s_a_y,
    input  wire logic [31:0] s_a_z,
    input  wire logic [31:0] s_a_w,
    input  wire logic [31:0] s_b_x,
    input  wire logic [31:0] s_b_y,
    input  wire logic [31:0] s_b_z,
    input  wire logic [31:0] s_b_w,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [31:0]      m_dir_x,
    output logic [31:0]      m_dir_y,
    output logic [31:0]      m_dir_z,
    output logic [31:0]      m_depth
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        ax, ay, az, aw, bx, by, bz, bw;
        logic signed [32:0] dx, dy, dz, rad;
    } st1_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        ax, ay, az, bx, by, bz;
        logic signed [32:0] dx, dy, dz, rad, awbw;
        logic signed [49:0] t0, t1, t2;
        logic [48:0]        r2;
    } st2_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        ax, ay, az, bx, by, bz;
        logic signed [32:0] dx, dy, dz, rad, awbw;
        logic signed [51:0] sum;
        logic [48:0]        r2;
    } st3_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] dir_x, dir_y, dir_z, depth;
    } res_t;

    logic en;
    logic v1_reg, v2_reg, v3_reg, vf_reg;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    res_t fin_reg, fin_next;
    res_t out_reg, skid_reg;
    logic m_valid_reg, skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // stage 1: differences and summed radius
    always_comb begin
        s1_next.kind = s_kind;
        s1_next.ax = s_a_x; s1_next.ay = s_a_y; s1_next.az = s_a_z; s1_next.aw = s_a_w;
        s1_next.bx = s_b_x; s1_next.by = s_b_y; s1_next.bz = s_b_z; s1_next.bw = s_b_w;
        s1_next.dx  = $signed({s_a_x[31], s_a_x}) - $signed({s_b_x[31], s_b_x});
        s1_next.dy  = $signed({s_a_y[31], s_a_y}) - $signed({s_b_y[31], s_b_y});
        s1_next.dz  = $signed({s_a_z[31], s_a_z}) - $signed({s_b_z[31], s_b_z});
        s1_next.rad = $signed({s_a_w[31], s_a_w}) + $signed({s_b_w[31], s_b_w});
    end

    // stage 2: products (dot terms or squared differences) and r squared
    logic               is_ss2;
    logic signed [32:0] mx0, my0, mx1, my1, mx2, my2;
    logic signed [65:0] p0, p1, p2, pr;

    assign is_ss2 = (s1_reg.kind == spc_pkg::KIND_SS);
    assign mx0 = is_ss2 ? s1_reg.dx : $signed({s1_reg.ax[31], s1_reg.ax});
    assign my0 = is_ss2 ? s1_reg.dx : $signed({s1_reg.bx[31], s1_reg.bx});
    assign mx1 = is_ss2 ? s1_reg.dy : $signed({s1_reg.ay[31], s1_reg.ay});
    assign my1 = is_ss2 ? s1_reg.dy : $signed({s1_reg.by[31], s1_reg.by});
    assign mx2 = is_ss2 ? s1_reg.dz : $signed({s1_reg.az[31], s1_reg.az});
    assign my2 = is_ss2 ? s1_reg.dz : $signed({s1_reg.bz[31], s1_reg.bz});
    assign p0  = mx0 * my0;
    assign p1  = mx1 * my1;
    assign p2  = mx2 * my2;
    assign pr  = s1_reg.rad * s1_reg.rad;

    always_comb begin
        s2_next.kind = s1_reg.kind;
        s2_next.ax = s1_reg.ax; s2_next.ay = s1_reg.ay; s2_next.az = s1_reg.az;
        s2_next.bx = s1_reg.bx; s2_next.by = s1_reg.by; s2_next.bz = s1_reg.bz;
        s2_next.dx = s1_reg.dx; s2_next.dy = s1_reg.dy; s2_next.dz = s1_reg.dz;
        s2_next.rad  = s1_reg.rad;
        s2_next.awbw = $signed({s1_reg.aw[31], s1_reg.aw}) - $signed({s1_reg.bw[31], s1_reg.bw});
        s2_next.t0 = $signed(p0[65:16]);
        s2_next.t1 = $signed(p1[65:16]);
        s2_next.t2 = $signed(p2[65:16]);
        s2_next.r2 = pr[64:16];
    end

    // stage 3: sum of terms
    always_comb begin
        s3_next.kind = s2_reg.kind;
        s3_next.ax = s2_reg.ax; s3_next.ay = s2_reg.ay; s3_next.az = s2_reg.az;
        s3_next.bx = s2_reg.bx; s3_next.by = s2_reg.by; s3_next.bz = s2_reg.bz;
        s3_next.dx = s2_reg.dx; s3_next.dy = s2_reg.dy; s3_next.dz = s2_reg.dz;
        s3_next.rad  = s2_reg.rad;
        s3_next.awbw = s2_reg.awbw;
        s3_next.r2   = s2_reg.r2;
        s3_next.sum  = $signed({{2{s2_reg.t0[49]}}, s2_reg.t0})
                     + $signed({{2{s2_reg.t1[49]}}, s2_reg.t1})
                     + $signed({{2{s2_reg.t2[49]}}, s2_reg.t2});
    end

    // decision, feeds the root pipeline
    logic signed [52:0] d1, d2, nd1, nd2, aw53;
    logic [31:0]        nbx, nby, nbz;
    spc_pkg::side_t     side4;
    logic [63:0]        rad4;

    assign aw53 = $signed({{20{s3_reg.awbw[32]}}, s3_reg.awbw});
    assign d1   = $signed({s3_reg.sum[51], s3_reg.sum}) + aw53;
    assign d2   = $signed({s3_reg.sum[51], s3_reg.sum}) - aw53;
    assign nd1  = -d1;
    assign nd2  = -d2;
    assign nbx  = (s3_reg.bx == spc_pkg::S32_MIN) ? spc_pkg::S32_MAX : 32'(-s3_reg.bx);
    assign nby  = (s3_reg.by == spc_pkg::S32_MIN) ? spc_pkg::S32_MAX : 32'(-s3_reg.by);
    assign nbz  = (s3_reg.bz == spc_pkg::S32_MIN) ? spc_pkg::S32_MAX : 32'(-s3_reg.bz);
    assign rad4 = {s3_reg.sum[47:0], 16'h0000};

    always_comb begin
        side4       = '0;
        side4.dif_x = s3_reg.dx;
        side4.dif_y = s3_reg.dy;
        side4.dif_z = s3_reg.dz;
        side4.rad   = s3_reg.rad;
        side4.big   = (s3_reg.sum[51:48] != 4'h0);
        case (s3_reg.kind)
            spc_pkg::KIND_PP: begin
                side4.hit = (s3_reg.sum < spc_pkg::Q_ONE) && (s3_reg.sum > -spc_pkg::Q_ONE);
                side4.dir_x = s3_reg.ax; side4.dir_y = s3_reg.ay; side4.dir_z = s3_reg.az;
            end
            spc_pkg::KIND_PS: begin
                side4.hit   = d1[52] || (d1 == 53'sd0);
                side4.dir_x = s3_reg.ax; side4.dir_y = s3_reg.ay; side4.dir_z = s3_reg.az;
                side4.depth = spc_pkg::sat_q($signed({{11{nd1[52]}}, nd1}));
            end
            spc_pkg::KIND_SP: begin
                side4.hit   = d2[52] || (d2 == 53'sd0);
                side4.dir_x = nbx; side4.dir_y = nby; side4.dir_z = nbz;
                side4.depth = spc_pkg::sat_q($signed({{11{nd2[52]}}, nd2}));
            end
            default: begin
                side4.sph = 1'b1;
                side4.hit = (s3_reg.sum <= $signed({3'b000, s3_reg.r2}));
            end
        endcase
        if (!side4.hit) begin
            side4.dir_x = '0; side4.dir_y = '0; side4.dir_z = '0; side4.depth = '0;
        end
    end

    logic           sq_valid;
    logic [31:0]    sq_root;
    spc_pkg::side_t sq_side;

    spc_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (rad4),
        .in_side   (side4),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic [32:0]      dv_len_in;
    logic [2:0][32:0] dv_mag_in;

    assign dv_len_in = sq_side.big ? spc_pkg::LEN_BIG : {1'b0, sq_root};
    assign dv_mag_in[0] = sq_side.dif_x[32] ? 33'(-sq_side.dif_x) : sq_side.dif_x;
    assign dv_mag_in[1] = sq_side.dif_y[32] ? 33'(-sq_side.dif_y) : sq_side.dif_y;
    assign dv_mag_in[2] = sq_side.dif_z[32] ? 33'(-sq_side.dif_z) : sq_side.dif_z;

    logic             dv_valid;
    logic [32:0]      dv_len;
    logic [2:0][23:0] dv_quo;
    spc_pkg::side_t   dv_side;

    spc_divq u_divq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (dv_len_in),
        .in_mag    (dv_mag_in),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_len   (dv_len),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // final: sphere direction sign, depth = r - len
    logic [31:0]        qx, qy, qz;
    logic signed [34:0] dep_s;

    assign qx    = {8'h00, dv_quo[0]};
    assign qy    = {8'h00, dv_quo[1]};
    assign qz    = {8'h00, dv_quo[2]};
    assign dep_s = $signed({{2{dv_side.rad[32]}}, dv_side.rad}) - $signed({2'b00, dv_len});

    always_comb begin
        fin_next.hit   = dv_side.hit;
        fin_next.dir_x = dv_side.dir_x;
        fin_next.dir_y = dv_side.dir_y;
        fin_next.dir_z = dv_side.dir_z;
        fin_next.depth = dv_side.depth;
        if (dv_side.sph && dv_side.hit) begin
            fin_next.depth = spc_pkg::sat_q($signed({{29{dep_s[34]}}, dep_s}));
            if (dv_len == 33'd0) begin
                fin_next.dir_x = '0; fin_next.dir_y = '0; fin_next.dir_z = '0;
            end else begin
                fin_next.dir_x = dv_side.dif_x[32] ? qx : 32'(-qx);
                fin_next.dir_y = dv_side.dif_y[32] ? qy : 32'(-qy);
                fin_next.dir_z = dv_side.dif_z[32] ? qz : 32'(-qz);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vf_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            fin_reg <= fin_next;
        end
    end

    // output register with skid beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vf_reg;
            end
        end else if (vf_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end else if (en) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = out_reg.hit;
    assign m_dir_x = out_reg.dir_x;
    assign m_dir_y = out_reg.dir_y;
    assign m_dir_z = out_reg.dir_z;
    assign m_depth = out_reg.depth;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid beat held with empty output register");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without output stall");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.hit) |->
            (out_reg.dir_x == 32'd0 && out_reg.dir_y == 32'd0 &&
             out_reg.dir_z == 32'd0 && out_reg.depth == 32'd0))
        else $error("miss beat with nonzero direction or depth");

endmodule
`default_nettype wire
